@@ rtl/fresnel_reflectance_assert.svh @@
// Assertion macros shared by the Fresnel reflectance RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef FRESNEL_REFLECTANCE_ASSERT_SVH
`define FRESNEL_REFLECTANCE_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define FR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition in one cycle that requires a consequence in the next cycle.
`define FR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fr_pkg.sv @@
// Package for the Fresnel reflectance block: fixed-point widths, case codes
// and the item structures passed between the front, queue and back parts.
// No dependencies.
`default_nettype none

package fr_pkg;

  // Fixed-point formats: cosines and reflectance Q1.30, indices Q2.16.
  localparam int unsigned COS_FRAC_BITS   = 30;
  localparam int unsigned INDEX_FRAC_BITS = 16;
  localparam int unsigned COS_W           = COS_FRAC_BITS + 1;
  localparam int unsigned IDX_W           = INDEX_FRAC_BITS + 2;
  localparam int unsigned CODE_W          = 3;

  // Derived datapath widths.
  localparam int unsigned SQ_W   = 2 * IDX_W;
  localparam int unsigned NUM1_W = SQ_W + COS_W;
  localparam int unsigned DEN1_W = 2 * (IDX_W + 1);
  localparam int unsigned RAD_W  = 2 * COS_W;
  localparam int unsigned NC_W   = IDX_W + COS_W - INDEX_FRAC_BITS;
  localparam int unsigned NUM2_W = NC_W + COS_FRAC_BITS;
  localparam int unsigned DEN2_W = NC_W + 1;

  // Depth of the queue between the classifier and the arithmetic pipeline.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [63:0] ONE_64 = 64'd1 << COS_FRAC_BITS;
  localparam logic [COS_W-1:0] ONE_FX = {1'b1, {COS_FRAC_BITS{1'b0}}};
  // Normal incidence when 1 - c1 is within 1e-12.
  localparam logic [COS_W-1:0] NORM_TOL = COS_W'(ONE_64 / 64'd1000000000000);
  // Grazing incidence when c1 is below 1e-6, i.e. below this bound.
  localparam logic [COS_W-1:0] GRAZE_LIM = COS_W'((ONE_64 + 64'd999999) / 64'd1000000);

  typedef enum logic [CODE_W-1:0] {
    CASE_MATCHED = 3'd0,
    CASE_NORMAL  = 3'd1,
    CASE_GRAZING = 3'd2,
    CASE_TIR     = 3'd3,
    CASE_GENERAL = 3'd4
  } case_e;

  // One classified item.
  typedef struct packed {
    logic [IDX_W-1:0] n1;
    logic [IDX_W-1:0] n2;
    logic [COS_W-1:0] c1;
    case_e            code;
  } fr_item_t;

  // An item offered to the queue, or the item at the queue head.
  typedef struct packed {
    logic     valid;
    fr_item_t item;
  } fr_push_t;

  // Per-item record that travels down the arithmetic pipeline.
  typedef struct packed {
    fr_item_t         item;
    logic [COS_W-1:0] r_norm;
    logic [COS_W-1:0] c2;
    logic             zero_s;
    logic             zero_p;
  } fr_track_t;

endpackage

`default_nettype wire

@@ rtl/fr_in_if.sv @@
// Input channel of the Fresnel reflectance block: valid/ready and the item.
// Depends on fr_pkg for field widths.
`default_nettype none

interface fr_in_if;
  logic                     valid;
  logic                     ready;
  logic [fr_pkg::IDX_W-1:0] index_incident;
  logic [fr_pkg::IDX_W-1:0] index_transmit;
  logic [fr_pkg::COS_W-1:0] incident_cosine;

  modport source (output valid, index_incident, index_transmit, incident_cosine,
                  input ready);
  modport sink (input valid, index_incident, index_transmit, incident_cosine,
                output ready);
endinterface

`default_nettype wire

@@ rtl/fr_out_if.sv @@
// Output channel of the Fresnel reflectance block: valid/ready and the result.
// Depends on fr_pkg for field widths.
`default_nettype none

interface fr_out_if;
  logic                      valid;
  logic                      ready;
  logic [fr_pkg::COS_W-1:0]  reflectance;
  logic [fr_pkg::COS_W-1:0]  transmit_cosine;
  logic [fr_pkg::CODE_W-1:0] case_code;

  modport source (output valid, reflectance, transmit_cosine, case_code, input ready);
  modport sink (input valid, reflectance, transmit_cosine, case_code, output ready);
endinterface

`default_nettype wire

@@ rtl/fr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// record carried alongside. Depends on fr_pkg for default widths.
`default_nettype none

module fr_div #(
  parameter int unsigned NUM_W = fr_pkg::NUM1_W,
  parameter int unsigned DEN_W = fr_pkg::DEN1_W,
  parameter int unsigned Q_W   = fr_pkg::COS_W,
  parameter type         side_t = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quo_o,
  output side_t            side_o
);

  // The partial remainder stays below the divisor, so one extra bit suffices.
  localparam int unsigned REM_W = DEN_W + 1;

  logic [Q_W-1:0]   valid_q;
  logic [REM_W-1:0] rem_q  [Q_W];
  logic [Q_W-1:0]   low_q  [Q_W];
  logic [Q_W-1:0]   quo_q  [Q_W];
  logic [DEN_W-1:0] den_q  [Q_W];
  side_t            side_q [Q_W];

  logic [REM_W-1:0] rem_in  [Q_W];
  logic [Q_W-1:0]   low_in  [Q_W];
  logic [Q_W-1:0]   quo_in  [Q_W];
  logic [DEN_W-1:0] den_in  [Q_W];
  side_t            side_in [Q_W];

  // Valid bits move with the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Q_W-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [REM_W-1:0] trial;
    logic             ge;

    // The first stage starts from the numerator bits above the quotient.
    if (k == 0) begin : g_first
      assign rem_in[k]  = REM_W'(num_i[NUM_W-1:Q_W]);
      assign low_in[k]  = num_i[Q_W-1:0];
      assign quo_in[k]  = '0;
      assign den_in[k]  = den_i;
      assign side_in[k] = side_i;
    end else begin : g_next
      assign rem_in[k]  = rem_q[k-1];
      assign low_in[k]  = low_q[k-1];
      assign quo_in[k]  = quo_q[k-1];
      assign den_in[k]  = den_q[k-1];
      assign side_in[k] = side_q[k-1];
    end

    // Shift in the next numerator bit and subtract when it fits.
    assign trial = {rem_in[k][REM_W-2:0], low_in[k][Q_W-1]};
    assign ge    = (trial >= {1'b0, den_in[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (trial - {1'b0, den_in[k]}) : trial;
        low_q[k]  <= low_in[k] << 1;
        quo_q[k]  <= {quo_in[k][Q_W-2:0], ge};
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = valid_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

`default_nettype wire

@@ rtl/fr_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, with a sideband
// record carried alongside. Depends on fr_pkg for default widths.
`default_nettype none

module fr_sqrt #(
  parameter int unsigned RAD_W  = fr_pkg::RAD_W,
  parameter int unsigned ROOT_W = RAD_W / 2,
  parameter type         side_t = logic
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output side_t             side_o
);

  // The remainder never exceeds twice the root.
  localparam int unsigned REM_W = ROOT_W + 3;

  logic [ROOT_W-1:0] valid_q;
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  side_t             side_q [ROOT_W];

  logic [REM_W-1:0]  rem_in  [ROOT_W];
  logic [ROOT_W-1:0] root_in [ROOT_W];
  logic [RAD_W-1:0]  rad_in  [ROOT_W];
  side_t             side_in [ROOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[ROOT_W-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] cand;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign rad_in[k]  = rad_i;
      assign side_in[k] = side_i;
    end else begin : g_next
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign rad_in[k]  = rad_q[k-1];
      assign side_in[k] = side_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign cand  = {rem_in[k][REM_W-3:0], rad_in[k][RAD_W-1 -: 2]};
    assign trial = REM_W'({root_in[k], 2'b01});
    assign ge    = (cand >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (cand - trial) : cand;
        root_q[k] <= {root_in[k][ROOT_W-2:0], ge};
        rad_q[k]  <= rad_in[k] << 2;
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = valid_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

`default_nettype wire

@@ rtl/fr_front.sv @@
// Front part: takes input items, clamps the cosine and sorts each item into
// its case before it enters the queue. Depends on fr_pkg and fr_in_if.
`default_nettype none

module fr_front (
  fr_in_if.sink             in_i,
  input  logic              full_i,
  output fr_pkg::fr_push_t  push_o
);

  logic [fr_pkg::COS_W-1:0] c1;

  // A cosine above one counts as one.
  assign c1 = (in_i.incident_cosine > fr_pkg::ONE_FX) ? fr_pkg::ONE_FX
                                                      : in_i.incident_cosine;

  assign in_i.ready = !full_i;

  // Classify; total internal reflection is told apart later in the back part.
  always_comb begin
    push_o.valid   = in_i.valid && !full_i;
    push_o.item.n1 = in_i.index_incident;
    push_o.item.n2 = in_i.index_transmit;
    push_o.item.c1 = c1;
    if (in_i.index_incident == in_i.index_transmit) begin
      push_o.item.code = fr_pkg::CASE_MATCHED;
    end else if ((fr_pkg::ONE_FX - c1) <= fr_pkg::NORM_TOL) begin
      push_o.item.code = fr_pkg::CASE_NORMAL;
    end else if (c1 < fr_pkg::GRAZE_LIM) begin
      push_o.item.code = fr_pkg::CASE_GRAZING;
    end else begin
      push_o.item.code = fr_pkg::CASE_GENERAL;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fr_queue.sv @@
// Short queue between the classifier and the arithmetic pipeline.
// Depends on fr_pkg and the assertion macro header.
`default_nettype none
`include "fresnel_reflectance_assert.svh"

module fr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fr_pkg::fr_push_t  push_i,
  output logic              full_o,
  input  logic              pop_i,
  output fr_pkg::fr_push_t  head_o
);

  fr_pkg::fr_item_t             mem_q [fr_pkg::QUEUE_DEPTH];
  logic [fr_pkg::QPTR_W-1:0]    wr_ptr_q;
  logic [fr_pkg::QPTR_W-1:0]    rd_ptr_q;
  logic [fr_pkg::QPTR_W:0]      cnt_q;

  assign full_o       = (cnt_q == (fr_pkg::QPTR_W + 1)'(fr_pkg::QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == fr_pkg::QPTR_W'(fr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == fr_pkg::QPTR_W'(fr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
      end
      if (push_i.valid && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i.valid) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  `FR_ASSERT(a_no_overflow, push_i.valid |-> !full_o, "push into a full queue")
  `FR_ASSERT(a_no_underflow, pop_i |-> head_o.valid, "pop from an empty queue")
  `FR_ASSERT_NEXT(a_cnt_up, push_i.valid && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "count did not rise")

endmodule

`default_nettype wire

@@ rtl/fr_back.sv @@
// Back part: the arithmetic pipeline that turns classified items into
// reflectance and transmission cosine, ending in the output register.
// Depends on fr_pkg, fr_out_if, fr_div, fr_sqrt and the assertion macros.
`default_nettype none
`include "fresnel_reflectance_assert.svh"

module fr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fr_pkg::fr_push_t  head_i,
  output logic              pop_o,
  fr_out_if.source          out_o
);

  localparam int unsigned C1SQ_W = 2 * fr_pkg::COS_W;
  localparam int unsigned PP_W   = fr_pkg::IDX_W + fr_pkg::COS_W;
  localparam int unsigned SUM_W  = fr_pkg::IDX_W + 1;
  localparam int unsigned SSQ_W  = 2 * SUM_W;

  logic adv;

  // Stage 1: squares of the indices and of the cosine, index difference and sum.
  logic                         s1_valid_q;
  fr_pkg::fr_track_t            s1_trk_q;
  logic [fr_pkg::SQ_W-1:0]      s1_n1sq_q, s1_n2sq_q;
  logic [C1SQ_W-1:0]            s1_c1sq_q;
  logic [fr_pkg::IDX_W-1:0]     s1_dif_q;
  logic [SUM_W-1:0]             s1_sum_q;
  // Stage 2: partial products of n1^2 * (1 - c1^2), and the normal-case terms.
  logic                         s2_valid_q;
  fr_pkg::fr_track_t            s2_trk_q;
  logic [PP_W-1:0]              s2_plo_q, s2_phi_q;
  logic [fr_pkg::SQ_W-1:0]      s2_dsq_q, s2_n2sq_q;
  logic [SSQ_W-1:0]             s2_ssq_q;
  logic [fr_pkg::COS_W-1:0]     s1sq;
  // Stage 3: total internal reflection test and divider operands.
  logic                         s3_valid_q;
  fr_pkg::fr_track_t            s3_trk_q, s3_trk_d;
  logic [fr_pkg::NUM1_W-1:0]    s3_num_q, s3_num_d, lhs, rhs;
  logic [fr_pkg::DEN1_W-1:0]    s3_den_q, s3_den_d;
  // First divider output and stage 4: square root operand.
  logic                         d1_valid;
  logic [fr_pkg::COS_W-1:0]     d1_quo;
  fr_pkg::fr_track_t            d1_trk;
  logic                         s4_valid_q;
  fr_pkg::fr_track_t            s4_trk_q;
  logic [fr_pkg::RAD_W-1:0]     s4_rad_q;
  // Square root output and stage 5: products n * c.
  logic                         sq_valid;
  logic [fr_pkg::COS_W-1:0]     sq_root;
  fr_pkg::fr_track_t            sq_trk;
  logic                         s5_valid_q;
  fr_pkg::fr_track_t            s5_trk_q;
  logic [PP_W-1:0]              p_n1c1, p_n2c2, p_n2c1, p_n1c2;
  logic [fr_pkg::NC_W-1:0]      s5_n1c1_q, s5_n2c2_q, s5_n2c1_q, s5_n1c2_q;
  // Stage 6: ratio operands.
  logic                         s6_valid_q;
  fr_pkg::fr_track_t            s6_trk_q, s6_trk_d;
  logic [fr_pkg::NUM2_W-1:0]    s6_num_s_q, s6_num_p_q;
  logic [fr_pkg::DEN2_W-1:0]    s6_den_s_q, s6_den_p_q, den_s, den_p;
  logic [fr_pkg::NC_W-1:0]      dif_s, dif_p;
  // Ratio dividers and stage 7: squared ratios.
  logic                         d2_valid;
  logic [fr_pkg::COS_W-1:0]     d2_qs, d2_qp, rs, rp;
  fr_pkg::fr_track_t            d2_trk;
  logic                         s7_valid_q;
  fr_pkg::fr_track_t            s7_trk_q;
  logic [C1SQ_W-1:0]            s7_sqs_q, s7_sqp_q;
  // Output register.
  logic                         out_valid_q;
  logic [fr_pkg::COS_W-1:0]     out_r_q, out_r_d, out_c2_q, out_c2_d, r_gen;
  fr_pkg::case_e                out_code_q;
  logic [fr_pkg::COS_W:0]       r_sum;

  // The whole pipeline moves while the output register can take a result.
  assign adv   = !out_valid_q || out_o.ready;
  assign pop_o = adv && head_i.valid;

  // Valid bits of the local stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= head_i.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= d1_valid;
      s5_valid_q  <= sq_valid;
      s6_valid_q  <= s5_valid_q;
      s7_valid_q  <= d2_valid;
      out_valid_q <= s7_valid_q;
    end
  end

  // Combinational terms between stages.
  assign s1sq = fr_pkg::ONE_FX - s1_c1sq_q[fr_pkg::COS_FRAC_BITS +: fr_pkg::COS_W];
  assign lhs  = (fr_pkg::NUM1_W'(s2_phi_q) << fr_pkg::IDX_W) + fr_pkg::NUM1_W'(s2_plo_q);
  assign rhs  = fr_pkg::NUM1_W'(s2_n2sq_q) << fr_pkg::COS_FRAC_BITS;

  always_comb begin
    s3_trk_d = s2_trk_q;
    if (s2_trk_q.item.code == fr_pkg::CASE_NORMAL) begin
      s3_num_d = fr_pkg::NUM1_W'(s2_dsq_q) << fr_pkg::COS_FRAC_BITS;
      s3_den_d = fr_pkg::DEN1_W'(s2_ssq_q);
    end else begin
      s3_num_d = lhs;
      s3_den_d = fr_pkg::DEN1_W'(s2_n2sq_q);
    end
    if ((s2_trk_q.item.code == fr_pkg::CASE_GENERAL) && !(rhs > lhs)) begin
      s3_trk_d.item.code = fr_pkg::CASE_TIR;
    end
  end

  // Products of an index and a cosine, truncated to Q3.30.
  assign p_n1c1 = PP_W'(sq_trk.item.n1) * PP_W'(sq_trk.item.c1);
  assign p_n2c2 = PP_W'(sq_trk.item.n2) * PP_W'(sq_root);
  assign p_n2c1 = PP_W'(sq_trk.item.n2) * PP_W'(sq_trk.item.c1);
  assign p_n1c2 = PP_W'(sq_trk.item.n1) * PP_W'(sq_root);

  // Sums and absolute differences for the s and p ratios.
  assign dif_s = (s5_n1c1_q > s5_n2c2_q) ? (s5_n1c1_q - s5_n2c2_q) : (s5_n2c2_q - s5_n1c1_q);
  assign dif_p = (s5_n2c1_q > s5_n1c2_q) ? (s5_n2c1_q - s5_n1c2_q) : (s5_n1c2_q - s5_n2c1_q);
  assign den_s = fr_pkg::DEN2_W'(s5_n1c1_q) + fr_pkg::DEN2_W'(s5_n2c2_q);
  assign den_p = fr_pkg::DEN2_W'(s5_n2c1_q) + fr_pkg::DEN2_W'(s5_n1c2_q);

  always_comb begin
    s6_trk_d        = s5_trk_q;
    s6_trk_d.zero_s = (den_s == '0);
    s6_trk_d.zero_p = (den_p == '0);
  end

  // A ratio with a zero denominator counts as one.
  assign rs = d2_trk.zero_s ? fr_pkg::ONE_FX : d2_qs;
  assign rp = d2_trk.zero_p ? fr_pkg::ONE_FX : d2_qp;

  // Mean of the squared ratios and the final selection by case.
  assign r_sum = (fr_pkg::COS_W + 1)'(s7_sqs_q[fr_pkg::COS_FRAC_BITS +: fr_pkg::COS_W])
               + (fr_pkg::COS_W + 1)'(s7_sqp_q[fr_pkg::COS_FRAC_BITS +: fr_pkg::COS_W]);
  assign r_gen = r_sum[fr_pkg::COS_W:1];

  always_comb begin
    case (s7_trk_q.item.code)
      fr_pkg::CASE_MATCHED: begin
        out_r_d  = '0;
        out_c2_d = s7_trk_q.item.c1;
      end
      fr_pkg::CASE_NORMAL: begin
        out_r_d  = s7_trk_q.r_norm;
        out_c2_d = s7_trk_q.item.c1;
      end
      fr_pkg::CASE_GRAZING, fr_pkg::CASE_TIR: begin
        out_r_d  = fr_pkg::ONE_FX;
        out_c2_d = '0;
      end
      fr_pkg::CASE_GENERAL: begin
        out_r_d  = r_gen;
        out_c2_d = s7_trk_q.c2;
      end
      default: begin
        out_r_d  = '0;
        out_c2_d = '0;
      end
    endcase
  end

  // Datapath registers of the local stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_trk_q        <= '{item: head_i.item, r_norm: '0, c2: '0, zero_s: 1'b0, zero_p: 1'b0};
      s1_n1sq_q       <= fr_pkg::SQ_W'(head_i.item.n1) * fr_pkg::SQ_W'(head_i.item.n1);
      s1_n2sq_q       <= fr_pkg::SQ_W'(head_i.item.n2) * fr_pkg::SQ_W'(head_i.item.n2);
      s1_c1sq_q       <= C1SQ_W'(head_i.item.c1) * C1SQ_W'(head_i.item.c1);
      s1_dif_q        <= (head_i.item.n1 > head_i.item.n2) ? (head_i.item.n1 - head_i.item.n2)
                                                           : (head_i.item.n2 - head_i.item.n1);
      s1_sum_q        <= SUM_W'(head_i.item.n1) + SUM_W'(head_i.item.n2);

      s2_trk_q        <= s1_trk_q;
      s2_plo_q        <= PP_W'(s1_n1sq_q[fr_pkg::IDX_W-1:0]) * PP_W'(s1sq);
      s2_phi_q        <= PP_W'(s1_n1sq_q[fr_pkg::SQ_W-1:fr_pkg::IDX_W]) * PP_W'(s1sq);
      s2_dsq_q        <= fr_pkg::SQ_W'(s1_dif_q) * fr_pkg::SQ_W'(s1_dif_q);
      s2_ssq_q        <= SSQ_W'(s1_sum_q) * SSQ_W'(s1_sum_q);
      s2_n2sq_q       <= s1_n2sq_q;

      s3_trk_q        <= s3_trk_d;
      s3_num_q        <= s3_num_d;
      s3_den_q        <= s3_den_d;

      s4_trk_q        <= '{item: d1_trk.item, r_norm: d1_quo, c2: '0, zero_s: 1'b0,
                           zero_p: 1'b0};
      s4_rad_q        <= fr_pkg::RAD_W'(fr_pkg::ONE_FX - d1_quo) << fr_pkg::COS_FRAC_BITS;

      s5_trk_q        <= '{item: sq_trk.item, r_norm: sq_trk.r_norm, c2: sq_root,
                           zero_s: 1'b0, zero_p: 1'b0};
      s5_n1c1_q       <= p_n1c1[PP_W-1:fr_pkg::INDEX_FRAC_BITS];
      s5_n2c2_q       <= p_n2c2[PP_W-1:fr_pkg::INDEX_FRAC_BITS];
      s5_n2c1_q       <= p_n2c1[PP_W-1:fr_pkg::INDEX_FRAC_BITS];
      s5_n1c2_q       <= p_n1c2[PP_W-1:fr_pkg::INDEX_FRAC_BITS];

      s6_trk_q        <= s6_trk_d;
      s6_num_s_q      <= fr_pkg::NUM2_W'(dif_s) << fr_pkg::COS_FRAC_BITS;
      s6_num_p_q      <= fr_pkg::NUM2_W'(dif_p) << fr_pkg::COS_FRAC_BITS;
      s6_den_s_q      <= den_s;
      s6_den_p_q      <= den_p;

      s7_trk_q        <= d2_trk;
      s7_sqs_q        <= C1SQ_W'(rs) * C1SQ_W'(rs);
      s7_sqp_q        <= C1SQ_W'(rp) * C1SQ_W'(rp);

      if (s7_valid_q) begin
        out_r_q    <= out_r_d;
        out_c2_q   <= out_c2_d;
        out_code_q <= s7_trk_q.item.code;
      end
    end
  end

  // s2 = n1^2 s1^2 / n2^2 in the general case, or the normal-incidence ratio.
  fr_div #(
    .NUM_W  (fr_pkg::NUM1_W),
    .DEN_W  (fr_pkg::DEN1_W),
    .Q_W    (fr_pkg::COS_W),
    .side_t (fr_pkg::fr_track_t)
  ) u_div_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_valid_q),
    .num_i   (s3_num_q),
    .den_i   (s3_den_q),
    .side_i  (s3_trk_q),
    .valid_o (d1_valid),
    .quo_o   (d1_quo),
    .side_o  (d1_trk)
  );

  // Transmission cosine from 1 - s2.
  fr_sqrt #(
    .RAD_W  (fr_pkg::RAD_W),
    .ROOT_W (fr_pkg::COS_W),
    .side_t (fr_pkg::fr_track_t)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s4_valid_q),
    .rad_i   (s4_rad_q),
    .side_i  (s4_trk_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_trk)
  );

  // s-polarized amplitude ratio.
  fr_div #(
    .NUM_W  (fr_pkg::NUM2_W),
    .DEN_W  (fr_pkg::DEN2_W),
    .Q_W    (fr_pkg::COS_W),
    .side_t (fr_pkg::fr_track_t)
  ) u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s6_valid_q),
    .num_i   (s6_num_s_q),
    .den_i   (s6_den_s_q),
    .side_i  (s6_trk_q),
    .valid_o (d2_valid),
    .quo_o   (d2_qs),
    .side_o  (d2_trk)
  );

  // p-polarized amplitude ratio, in step with the s divider.
  fr_div #(
    .NUM_W  (fr_pkg::NUM2_W),
    .DEN_W  (fr_pkg::DEN2_W),
    .Q_W    (fr_pkg::COS_W),
    .side_t (logic)
  ) u_div_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s6_valid_q),
    .num_i   (s6_num_p_q),
    .den_i   (s6_den_p_q),
    .side_i  (1'b0),
    .valid_o (),
    .quo_o   (d2_qp),
    .side_o  ()
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.reflectance     = out_r_q;
  assign out_o.transmit_cosine = out_c2_q;
  assign out_o.case_code       = out_code_q;

  `FR_ASSERT(a_tir_result, out_valid_q && (out_code_q == fr_pkg::CASE_TIR) |-> (out_r_q == fr_pkg::ONE_FX) && (out_c2_q == '0), "reflected item without full reflectance")
  `FR_ASSERT_NEXT(a_fill, adv && s7_valid_q, out_valid_q, "last stage result not registered")
  `FR_ASSERT_NEXT(a_stall_hold, !adv, $stable(s7_valid_q), "pipeline moved during a stall")

endmodule

`default_nettype wire

@@ rtl/fresnel_reflectance.sv @@
// Top level of the Fresnel reflectance block: classifier, queue and
// arithmetic pipeline. Depends on fr_pkg, fr_in_if, fr_out_if and submodules.
//
// Usage:
//   in_i carries one item per transfer: incident and transmit refractive
//   indices (Q2.16) and the incidence cosine (Q1.30). out_o returns one result
//   per item, in order: reflectance and transmission cosine (Q1.30) and a case
//   code (matched, normal, grazing, total internal reflection, general).
//   Throughput is one item per cycle while out_o does not stall. From an input
//   transfer to valid on out_o the item passes three stages of products and
//   the reflection test, the first of which reads the queue head, a 31-stage
//   divider for the transmitted sine, one operand stage, a 31-stage square
//   root, two stages of index-cosine products and ratio operands, two 31-stage
//   ratio dividers side by side, one squaring stage and the output register.
//   When out_o stalls, the whole pipeline holds; the four-entry queue keeps
//   taking items until it fills, then in_i.ready falls.
//   Reset empties the queue and clears all valid bits; no result is pending
//   afterwards and the block takes items as soon as reset is released.
`default_nettype none

module fresnel_reflectance (
  input  logic      clk_i,
  input  logic      rst_ni,
  fr_in_if.sink     in_i,
  fr_out_if.source  out_o
);

  fr_pkg::fr_push_t push;
  fr_pkg::fr_push_t head;
  logic             full;
  logic             pop;

  fr_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  fr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  fr_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
